// ===== src/htok_pkg.sv =====
// shared types and constants of the request head tokenizer
package htok_pkg;

  typedef enum logic [2:0] {
    KIND_METHOD  = 3'd0,
    KIND_URI     = 3'd1,
    KIND_VERSION = 3'd2,
    KIND_KEY     = 3'd3,
    KIND_VALUE   = 3'd4,
    KIND_DONE    = 3'd5
  } token_kind_t;

  // request line: start, method, space, uri, space, version
  // header line: start, key, space, value
  typedef enum logic [2:0] {
    LS_START = 3'd0,
    LS_TOK1  = 3'd1,
    LS_SP1   = 3'd2,
    LS_TOK2  = 3'd3,
    LS_SP2   = 3'd4,
    LS_TOK3  = 3'd5
  } line_state_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam int unsigned POS_W = 16;

  typedef struct packed {
    token_kind_t        kind;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   end_pos;
    logic               sat;
  } token_t;

endpackage

// ===== src/htok_if.sv =====
// request channels: byte stream in, token stream out
interface htok_byte_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface htok_token_if (input logic clk);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    token_kind;
  logic [htok_pkg::POS_W-1:0]    token_start;
  logic [htok_pkg::POS_W-1:0]    token_end;
  logic                          position_saturated;

  modport source (output valid, output token_kind, output token_start, output token_end,
                  output position_saturated, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_end,
                input position_saturated, output ready);
endinterface

// ===== src/htok_core.sv =====
// line state machine, byte offset and token boundary tracking
module htok_core #(
  parameter logic [htok_pkg::POS_W-1:0] MAX_POS = 16'hffff
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic [7:0]       data_byte,
  output logic             res_valid,
  output htok_pkg::token_t res
);

  htok_pkg::line_state_t         line_state, line_state_next;
  logic                          in_headers, in_headers_next;
  logic [htok_pkg::POS_W-1:0]    byte_position, byte_position_next;
  logic [htok_pkg::POS_W-1:0]    token_start, token_start_next;
  logic [htok_pkg::POS_W-1:0]    prev_pos;
  logic                          sat;
  logic                          hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_state    <= htok_pkg::LS_START;
      in_headers    <= 1'b0;
      byte_position <= '0;
      token_start   <= '0;
    end else if (in_fire) begin
      line_state    <= line_state_next;
      in_headers    <= in_headers_next;
      byte_position <= byte_position_next;
      token_start   <= token_start_next;
    end
  end

  assign sat                = (byte_position == MAX_POS);
  assign prev_pos           = byte_position - 16'd1;
  assign byte_position_next = sat ? byte_position : byte_position + 16'd1;

  always_comb begin
    line_state_next = line_state;
    in_headers_next = in_headers;
    token_start_next = token_start;
    hit             = 1'b0;
    res.kind        = htok_pkg::KIND_METHOD;
    res.start_pos   = token_start;
    res.end_pos     = byte_position;
    res.sat         = sat;
    if (!in_headers) begin
      case (line_state)
        htok_pkg::LS_TOK1: begin
          if (data_byte == htok_pkg::CH_SPACE) begin
            hit             = 1'b1;
            res.kind        = htok_pkg::KIND_METHOD;
            line_state_next = htok_pkg::LS_SP1;
          end
        end
        htok_pkg::LS_SP1: begin
          token_start_next = byte_position;
          line_state_next  = htok_pkg::LS_TOK2;
        end
        htok_pkg::LS_TOK2: begin
          if (data_byte == htok_pkg::CH_SPACE) begin
            hit             = 1'b1;
            res.kind        = htok_pkg::KIND_URI;
            line_state_next = htok_pkg::LS_SP2;
          end
        end
        htok_pkg::LS_SP2: begin
          token_start_next = byte_position;
          line_state_next  = htok_pkg::LS_TOK3;
        end
        htok_pkg::LS_TOK3: begin
          if (data_byte == htok_pkg::CH_LF) begin
            hit             = 1'b1;
            res.kind        = htok_pkg::KIND_VERSION;
            res.end_pos     = prev_pos;
            line_state_next = htok_pkg::LS_START;
            in_headers_next = 1'b1;
          end
        end
        default: begin
          token_start_next = byte_position;
          line_state_next  = htok_pkg::LS_TOK1;
        end
      endcase
    end else begin
      case (line_state)
        htok_pkg::LS_TOK1: begin
          if (data_byte == htok_pkg::CH_SPACE) begin
            hit             = 1'b1;
            res.kind        = htok_pkg::KIND_KEY;
            res.end_pos     = prev_pos;
            line_state_next = htok_pkg::LS_SP1;
          end
        end
        htok_pkg::LS_SP1: begin
          token_start_next = byte_position;
          line_state_next  = htok_pkg::LS_TOK2;
        end
        htok_pkg::LS_TOK2: begin
          if (data_byte == htok_pkg::CH_LF) begin
            hit             = 1'b1;
            res.kind        = htok_pkg::KIND_VALUE;
            res.end_pos     = prev_pos;
            line_state_next = htok_pkg::LS_START;
          end
        end
        default: begin
          if (data_byte == htok_pkg::CH_CR) begin
            line_state_next = htok_pkg::LS_START;
          end else if (data_byte == htok_pkg::CH_LF) begin
            // empty line closes the head, back to a fresh request line
            hit             = 1'b1;
            res.kind        = htok_pkg::KIND_DONE;
            res.start_pos   = byte_position;
            line_state_next = htok_pkg::LS_START;
            in_headers_next = 1'b0;
          end else begin
            token_start_next = byte_position;
            line_state_next  = htok_pkg::LS_TOK1;
          end
        end
      endcase
    end
  end

  assign res_valid = in_fire & hit;

  a_pos_count: assert property (@(posedge clk) disable iff (rst)
    in_fire && !sat |=> byte_position == $past(byte_position) + 16'd1)
    else $error("byte offset did not advance");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(byte_position) && $stable(line_state))
    else $error("state moved without a request");

  a_hdr_state: assert property (@(posedge clk) disable iff (rst)
    in_headers |-> (line_state == htok_pkg::LS_START || line_state == htok_pkg::LS_TOK1 ||
                    line_state == htok_pkg::LS_SP1 || line_state == htok_pkg::LS_TOK2))
    else $error("header phase in a request line sub-state");

endmodule

// ===== src/htok_skid.sv =====
// output register with one skid entry for token results
module htok_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  htok_pkg::token_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output htok_pkg::token_t out_data
);

  logic             skid_valid;
  htok_pkg::token_t skid_data;
  logic             pop;

  assign pop  = out_valid & out_ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else if (!push) begin
          out_valid <= 1'b0;
        end
      end else if (push) begin
        if (out_valid) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without an output entry");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into a full buffer");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid && $stable(skid_data))
    else $error("skid entry lost while stalled");

endmodule

// ===== src/http_request_head_tokenizer_unit.sv =====
// top level of the request head tokenizer
//
//  channel    dir  handshake      payload
//  byte_in    in   valid/ready    data_byte[7:0]
//  token_out  out  valid/ready    token_kind[2:0] token_start[15:0] token_end[15:0]
//                                 position_saturated
//
// one byte per cycle while byte_in.ready is high; a token result is registered on the byte that closes it
// the line state machine and offset update sit between the byte input and the result
// register, so throughput is set by that single state update loop
// reset (rst, synchronous) returns to request line start at offset zero
// a stalled output fills the skid entry; byte_in.ready drops only while it is full
module http_request_head_tokenizer_unit #(
  parameter longint unsigned HEAD_BYTES = 65536
) (
  input  logic          clk,
  input  logic          rst,
  htok_byte_if.sink     byte_in,
  htok_token_if.source  token_out
);

  localparam longint unsigned LIMIT = (HEAD_BYTES > 64'd65536) ? 64'd65536 :
                                      ((HEAD_BYTES == 64'd0) ? 64'd1 : HEAD_BYTES);
  localparam logic [htok_pkg::POS_W-1:0] MAX_POS = htok_pkg::POS_W'(LIMIT - 64'd1);

  logic             in_fire;
  logic             res_valid;
  htok_pkg::token_t res;
  logic             full;
  htok_pkg::token_t out_data;

  assign byte_in.ready = ~full;
  assign in_fire       = byte_in.valid & ~full;

  htok_core #(
    .MAX_POS (MAX_POS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (byte_in.data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  htok_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (token_out.valid),
    .out_ready (token_out.ready),
    .out_data  (out_data)
  );

  assign token_out.token_kind         = out_data.kind;
  assign token_out.token_start        = out_data.start_pos;
  assign token_out.token_end          = out_data.end_pos;
  assign token_out.position_saturated = out_data.sat;

endmodule

// ===== test/tb.sv =====
// testbench for the request head tokenizer: byte stream in, checked token stream out
module tb;

  localparam longint unsigned HEAD_BYTES = 65536;
  localparam logic [15:0] MAXP = (HEAD_BYTES > 65536) ? 16'hffff : 16'(HEAD_BYTES - 1);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0]            b;
    bit                    typed;
    htok_pkg::token_kind_t kind;
    logic [15:0]           s;
    logic [15:0]           e;
  } dir_row_t;

  logic clk;
  logic rst;

  htok_byte_if  byte_in (clk);
  htok_token_if token_out (clk);

  http_request_head_tokenizer_unit #(.HEAD_BYTES(HEAD_BYTES)) u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .token_out (token_out)
  );

  // predicted tokenizer state
  logic                  hdr_phase;
  htok_pkg::line_state_t lstate;
  logic [15:0]           next_pos;
  logic [15:0]           open_start;

  htok_pkg::token_t pending_tokens[$];
  logic [7:0]       req_bytes[$];
  int               bad_tokens;
  int               cycle_count;
  int               idle_pct;
  int               stall_pct;
  bit               hold_kick;

  // typed rows come straight from a request starting at offset zero
  dir_row_t dir_rows [28] = '{
    '{"G", 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{"E", 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{"T", 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_SPACE, 1'b1, htok_pkg::KIND_METHOD, 16'd0, 16'd3},
    '{"/", 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_SPACE, 1'b1, htok_pkg::KIND_URI, 16'd4, 16'd5},
    '{"H", 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_LF, 1'b1, htok_pkg::KIND_VERSION, 16'd6, 16'd6},
    '{"k", 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_SPACE, 1'b1, htok_pkg::KIND_KEY, 16'd8, 16'd8},
    '{"v", 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_LF, 1'b1, htok_pkg::KIND_VALUE, 16'd10, 16'd10},
    '{htok_pkg::CH_CR, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_LF, 1'b1, htok_pkg::KIND_DONE, 16'd13, 16'd13},
    // newline opens a method, spaces open uri and version
    '{htok_pkg::CH_LF, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_SPACE, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_SPACE, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{8'hff, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_SPACE, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_SPACE, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_CR, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_LF, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    // key holding a newline, value opened by a newline
    '{8'h00, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_LF, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_SPACE, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_LF, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_LF, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0},
    '{htok_pkg::CH_LF, 1'b0, htok_pkg::KIND_METHOD, 16'd0, 16'd0}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bit tokenize_byte(input logic [7:0] b, output htok_pkg::token_t tk);
    logic [15:0] p;
    logic [15:0] prev;
    logic        at_max;
    bit          hit;
    p = next_pos;
    at_max = (p == MAXP);
    prev = p - 16'd1;
    hit = 1'b0;
    tk = '0;
    if (!hdr_phase) begin
      case (lstate)
        htok_pkg::LS_TOK1: if (b == htok_pkg::CH_SPACE) begin
          tk = '{htok_pkg::KIND_METHOD, open_start, p, at_max};
          hit = 1'b1;
          lstate = htok_pkg::LS_SP1;
        end
        htok_pkg::LS_SP1: begin
          open_start = p;
          lstate = htok_pkg::LS_TOK2;
        end
        htok_pkg::LS_TOK2: if (b == htok_pkg::CH_SPACE) begin
          tk = '{htok_pkg::KIND_URI, open_start, p, at_max};
          hit = 1'b1;
          lstate = htok_pkg::LS_SP2;
        end
        htok_pkg::LS_SP2: begin
          open_start = p;
          lstate = htok_pkg::LS_TOK3;
        end
        htok_pkg::LS_TOK3: if (b == htok_pkg::CH_LF) begin
          tk = '{htok_pkg::KIND_VERSION, open_start, prev, at_max};
          hit = 1'b1;
          lstate = htok_pkg::LS_START;
          hdr_phase = 1'b1;
        end
        default: begin
          open_start = p;
          lstate = htok_pkg::LS_TOK1;
        end
      endcase
    end else begin
      case (lstate)
        htok_pkg::LS_TOK1: if (b == htok_pkg::CH_SPACE) begin
          tk = '{htok_pkg::KIND_KEY, open_start, prev, at_max};
          hit = 1'b1;
          lstate = htok_pkg::LS_SP1;
        end
        htok_pkg::LS_SP1: begin
          open_start = p;
          lstate = htok_pkg::LS_TOK2;
        end
        htok_pkg::LS_TOK2: if (b == htok_pkg::CH_LF) begin
          tk = '{htok_pkg::KIND_VALUE, open_start, prev, at_max};
          hit = 1'b1;
          lstate = htok_pkg::LS_START;
        end
        default: begin
          if (b == htok_pkg::CH_CR) begin
            lstate = htok_pkg::LS_START;
          end else if (b == htok_pkg::CH_LF) begin
            tk = '{htok_pkg::KIND_DONE, p, p, at_max};
            hit = 1'b1;
            lstate = htok_pkg::LS_START;
            hdr_phase = 1'b0;
          end else begin
            open_start = p;
            lstate = htok_pkg::LS_TOK1;
          end
        end
      endcase
    end
    next_pos = (p < MAXP) ? p + 16'd1 : MAXP;
    return hit;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [7:0] no_a, input logic [7:0] no_b);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 9) < 7) b = 8'($urandom_range(33, 126));
      else b = 8'($urandom_range(0, 255));
    end while (b == no_a || b == no_b);
    return b;
  endfunction

  // drive one byte, then wait for its request to be taken
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input htok_pkg::token_t given);
    htok_pkg::token_t tk;
    bit               hit;
    while ($urandom_range(0, 99) < idle_pct) begin
      byte_in.valid <= 1'b0;
      @(posedge clk);
    end
    byte_in.valid <= 1'b1;
    byte_in.data_byte <= b;
    do @(posedge clk); while (!byte_in.ready);
    hit = tokenize_byte(b, tk);
    if (typed) pending_tokens.push_back(given);
    else if (hit) pending_tokens.push_back(tk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  task automatic wait_drain();
    byte_in.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_token(input logic [7:0] first_a, input logic [7:0] first_b,
                           input logic [7:0] stop);
    int len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 5);
    req_bytes.push_back(pick_byte(first_a, first_b));
    repeat (len - 1) req_bytes.push_back(pick_byte(stop, stop));
  endtask

  task automatic build_request();
    req_bytes.delete();
    add_token(htok_pkg::CH_SPACE, htok_pkg::CH_SPACE, htok_pkg::CH_SPACE);
    req_bytes.push_back(htok_pkg::CH_SPACE);
    add_token(htok_pkg::CH_SPACE, htok_pkg::CH_SPACE, htok_pkg::CH_SPACE);
    req_bytes.push_back(htok_pkg::CH_SPACE);
    add_token(htok_pkg::CH_LF, htok_pkg::CH_LF, htok_pkg::CH_LF);
    req_bytes.push_back(htok_pkg::CH_LF);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 3) == 0) req_bytes.push_back(htok_pkg::CH_CR);
      add_token(htok_pkg::CH_CR, htok_pkg::CH_LF, htok_pkg::CH_SPACE);
      req_bytes.push_back(htok_pkg::CH_SPACE);
      add_token(htok_pkg::CH_LF, htok_pkg::CH_LF, htok_pkg::CH_LF);
      if ($urandom_range(0, 1) == 0) req_bytes.push_back(htok_pkg::CH_CR);
      req_bytes.push_back(htok_pkg::CH_LF);
    end
    if ($urandom_range(0, 1) == 0) req_bytes.push_back(htok_pkg::CH_CR);
    req_bytes.push_back(htok_pkg::CH_LF);
  endtask

  // mostly clean request heads, some cut short or salted with noise
  task automatic run_traffic(input int n_bytes);
    int sent;
    int roll;
    sent = 0;
    while (sent < n_bytes) begin
      build_request();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        req_bytes = req_bytes[0:$urandom_range(0, req_bytes.size() - 1)];
      end else if (roll < 16) begin
        repeat ($urandom_range(1, 8))
          req_bytes.insert($urandom_range(0, req_bytes.size()), 8'($urandom_range(0, 255)));
      end
      foreach (req_bytes[i]) push_byte(req_bytes[i]);
      sent += req_bytes.size();
    end
  endtask

  // token checker and ready driver
  initial begin
    htok_pkg::token_t want;
    bit               hold_seen;
    int               hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    token_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && token_out.valid && token_out.ready) begin
        if (pending_tokens.size() == 0) begin
          bad_tokens++;
          if (bad_tokens <= 10)
            $display("unexpected token: kind %0d start %0d end %0d sat %0d",
                     token_out.token_kind, token_out.token_start, token_out.token_end,
                     token_out.position_saturated);
        end else begin
          want = pending_tokens.pop_front();
          if (token_out.token_kind !== want.kind || token_out.token_start !== want.start_pos ||
              token_out.token_end !== want.end_pos || token_out.position_saturated !== want.sat)
          begin
            bad_tokens++;
            if (bad_tokens <= 10)
              $display("token mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.kind, want.start_pos, want.end_pos, want.sat,
                       token_out.token_kind, token_out.token_start, token_out.token_end,
                       token_out.position_saturated);
          end
        end
      end
      if (hold_kick != hold_seen) begin
        hold_seen = hold_kick;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        token_out.ready <= 1'b0;
      end else begin
        token_out.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    int               idle_tab [4];
    int               stall_tab [4];
    htok_pkg::token_t given;
    logic [7:0]       b;
    idle_tab = '{0, 72, 0, 16};
    stall_tab = '{0, 0, 72, 16};
    hdr_phase = 1'b0;
    lstate = htok_pkg::LS_START;
    next_pos = '0;
    open_start = '0;
    bad_tokens = 0;
    cycle_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_kick = 1'b0;
    rst <= 1'b1;
    byte_in.valid <= 1'b0;
    byte_in.data_byte <= 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      given = '{dir_rows[i].kind, dir_rows[i].s, dir_rows[i].e, 1'b0};
      send_byte(dir_rows[i].b, dir_rows[i].typed, given);
    end
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      run_traffic(280);
      wait_drain();
    end

    // long output hold while bytes keep coming, so the input backs up
    idle_pct = 0;
    stall_pct = 0;
    hold_kick = ~hold_kick;
    run_traffic(100);
    wait_drain();

    // steer into a uri and stretch it
    stall_pct = 20;
    while (hdr_phase || lstate != htok_pkg::LS_TOK2) begin
      if (hdr_phase) begin
        case (lstate)
          htok_pkg::LS_TOK1: b = htok_pkg::CH_SPACE;
          htok_pkg::LS_SP1:  b = "x";
          default:           b = htok_pkg::CH_LF;
        endcase
      end else begin
        case (lstate)
          htok_pkg::LS_TOK1: b = htok_pkg::CH_SPACE;
          htok_pkg::LS_SP1:  b = "/";
          htok_pkg::LS_SP2:  b = "v";
          htok_pkg::LS_TOK3: b = htok_pkg::CH_LF;
          default:           b = "G";
        endcase
      end
      push_byte(b);
    end
    repeat (20) push_byte(pick_byte(htok_pkg::CH_SPACE, htok_pkg::CH_SPACE));
    push_byte(htok_pkg::CH_SPACE);
    push_byte("V");
    push_byte(htok_pkg::CH_LF);
    push_byte(htok_pkg::CH_LF);
    idle_pct = 16;
    run_traffic(80);
    wait_drain();

    repeat (8) @(posedge clk);
    if (bad_tokens == 0 && pending_tokens.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
